[sv/aesirt_pkg.sv]
package aesirt_pkg;

   localparam int NB = 4;
   localparam int ROWS = 4;
   localparam int NBYTES = 16;

   localparam logic [1:0] OP_INV_SHIFT_ROWS = 2'd0;
   localparam logic [1:0] OP_INV_SUB_BYTES  = 2'd1;
   localparam logic [1:0] OP_INV_MIX_COLS   = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] state_hi;
      logic [63:0] state_lo;
   } req_type_type;

   typedef struct packed {
      logic [63:0] result_hi;
      logic [63:0] result_lo;
   } rsp_type;

   typedef logic [NBYTES-1:0][7:0] state_type;

   localparam logic [255:0][7:0] INV_SBOX = {
      8'h7d, 8'h0c, 8'h21, 8'h55, 8'h63, 8'h14, 8'h69, 8'he1,
      8'h26, 8'hd6, 8'h77, 8'hba, 8'h7e, 8'h04, 8'h2b, 8'h17,
      8'h61, 8'h99, 8'h53, 8'h83, 8'h3c, 8'hbb, 8'heb, 8'hc8,
      8'hb0, 8'hf5, 8'h2a, 8'hae, 8'h4d, 8'h3b, 8'he0, 8'ha0,
      8'hef, 8'h9c, 8'hc9, 8'h93, 8'h9f, 8'h7a, 8'he5, 8'h2d,
      8'h0d, 8'h4a, 8'hb5, 8'h19, 8'ha9, 8'h7f, 8'h51, 8'h60,
      8'h5f, 8'hec, 8'h80, 8'h27, 8'h59, 8'h10, 8'h12, 8'hb1,
      8'h31, 8'hc7, 8'h07, 8'h88, 8'h33, 8'ha8, 8'hdd, 8'h1f,
      8'hf4, 8'h5a, 8'hcd, 8'h78, 8'hfe, 8'hc0, 8'hdb, 8'h9a,
      8'h20, 8'h79, 8'hd2, 8'hc6, 8'h4b, 8'h3e, 8'h56, 8'hfc,
      8'h1b, 8'hbe, 8'h18, 8'haa, 8'h0e, 8'h62, 8'hb7, 8'h6f,
      8'h89, 8'hc5, 8'h29, 8'h1d, 8'h71, 8'h1a, 8'hf1, 8'h47,
      8'h6e, 8'hdf, 8'h75, 8'h1c, 8'he8, 8'h37, 8'hf9, 8'he2,
      8'h85, 8'h35, 8'had, 8'he7, 8'h22, 8'h74, 8'hac, 8'h96,
      8'h73, 8'he6, 8'hb4, 8'hf0, 8'hce, 8'hcf, 8'hf2, 8'h97,
      8'hea, 8'hdc, 8'h67, 8'h4f, 8'h41, 8'h11, 8'h91, 8'h3a,
      8'h6b, 8'h8a, 8'h13, 8'h01, 8'h03, 8'hbd, 8'haf, 8'hc1,
      8'h02, 8'h0f, 8'h3f, 8'hca, 8'h8f, 8'h1e, 8'h2c, 8'hd0,
      8'h06, 8'h45, 8'hb3, 8'hb8, 8'h05, 8'h58, 8'he4, 8'hf7,
      8'h0a, 8'hd3, 8'hbc, 8'h8c, 8'h00, 8'hab, 8'hd8, 8'h90,
      8'h84, 8'h9d, 8'h8d, 8'ha7, 8'h57, 8'h46, 8'h15, 8'h5e,
      8'hda, 8'hb9, 8'hed, 8'hfd, 8'h50, 8'h48, 8'h70, 8'h6c,
      8'h92, 8'hb6, 8'h65, 8'h5d, 8'hcc, 8'h5c, 8'ha4, 8'hd4,
      8'h16, 8'h98, 8'h68, 8'h86, 8'h64, 8'hf6, 8'hf8, 8'h72,
      8'h25, 8'hd1, 8'h8b, 8'h6d, 8'h49, 8'ha2, 8'h5b, 8'h76,
      8'hb2, 8'h24, 8'hd9, 8'h28, 8'h66, 8'ha1, 8'h2e, 8'h08,
      8'h4e, 8'hc3, 8'hfa, 8'h42, 8'h0b, 8'h95, 8'h4c, 8'hee,
      8'h3d, 8'h23, 8'hc2, 8'ha6, 8'h32, 8'h94, 8'h7b, 8'h54,
      8'hcb, 8'he9, 8'hde, 8'hc4, 8'h44, 8'h43, 8'h8e, 8'h34,
      8'h87, 8'hff, 8'h2f, 8'h9b, 8'h82, 8'h39, 8'he3, 8'h7c,
      8'hfb, 8'hd7, 8'hf3, 8'h81, 8'h9e, 8'ha3, 8'h40, 8'hbf,
      8'h38, 8'ha5, 8'h36, 8'h30, 8'hd5, 8'h6a, 8'h09, 8'h52
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

endpackage

[sv/aes_inverse_round_transforms.sv]
// The result is held in one output register and is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the output is not stalled; four column lanes work in parallel.
// A request is taken while the held result is being taken in the same cycle.
// Reset: synchronous, active high; clears the result valid, no payload reset.
module aes_inverse_round_transforms (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  aesirt_pkg::req_type_type  req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output aesirt_pkg::rsp_type       rsp_data
);
   import aesirt_pkg::*;

   state_type st;
   state_type sub_st;
   state_type mix_st;
   state_type res;
   logic      valid_ff;
   logic      valid_in;
   rsp_type   data_ff;
   rsp_type   data_in;
   logic      take;

   assign st = {req_data.state_hi, req_data.state_lo};

   // state byte k sits at st[15-k]
   for (genvar c = 0; c < NB; c++) begin : g_lane
      logic [3:0][7:0] col;
      logic [3:0][7:0] sb;
      logic [3:0][7:0] mx;
      for (genvar r = 0; r < ROWS; r++) begin : g_row
         assign col[r] = st[15 - (r*NB + c)];
         assign sub_st[15 - (r*NB + c)] = sb[r];
         assign mix_st[15 - (r*NB + c)] = mx[r];
      end
      aesirt_lane u_lane (
         .col_in  (col),
         .sub_out (sb),
         .mix_out (mx)
      );
   end

   state_type st_r;
   state_type sub_r;
   state_type mix_r;
   state_type res_r;

   always_comb begin
      for (int k = 0; k < NBYTES; k++) begin
         st_r[k]  = st[15 - k];
         sub_r[k] = sub_st[15 - k];
         mix_r[k] = mix_st[15 - k];
         res[15 - k] = res_r[k];
      end
   end

   aesirt_merge u_merge (
      .op     (req_data.req_type),
      .st     (st_r),
      .sub_st (sub_r),
      .mix_st (mix_r),
      .res    (res_r)
   );

   assign req_stall = valid_ff & rsp_stall;
   assign take      = req_valid & ~req_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (take) begin
         valid_in = 1'b1;
         data_in  = {res[15:8], res[7:0]};
      end else if (~rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
endmodule

[sv/aesirt_lane.sv]
// One column: inverse S-box on its four bytes and inverse mix of the column.
module aesirt_lane (
   input  logic [3:0][7:0] col_in,
   output logic [3:0][7:0] sub_out,
   output logic [3:0][7:0] mix_out
);
   import aesirt_pkg::*;

   logic [3:0][7:0] x2;
   logic [3:0][7:0] x4;
   logic [3:0][7:0] x8;
   logic [3:0][7:0] m9;
   logic [3:0][7:0] mb;
   logic [3:0][7:0] md;
   logic [3:0][7:0] me;

   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         sub_out[r] = INV_SBOX[col_in[r]];
         x2[r] = xtime(col_in[r]);
         x4[r] = xtime(x2[r]);
         x8[r] = xtime(x4[r]);
         m9[r] = x8[r] ^ col_in[r];
         mb[r] = x8[r] ^ x2[r] ^ col_in[r];
         md[r] = x8[r] ^ x4[r] ^ col_in[r];
         me[r] = x8[r] ^ x4[r] ^ x2[r];
      end
      for (int r = 0; r < ROWS; r++) begin
         mix_out[r] = me[r] ^ mb[(r + 1) % 4] ^ md[(r + 2) % 4] ^ m9[(r + 3) % 4];
      end
   end
endmodule

[sv/aesirt_merge.sv]
// Merges lane results with the row rotation and selects by operation.
module aesirt_merge (
   input  logic [1:0]             op,
   input  aesirt_pkg::state_type  st,
   input  aesirt_pkg::state_type  sub_st,
   input  aesirt_pkg::state_type  mix_st,
   output aesirt_pkg::state_type  res
);
   import aesirt_pkg::*;

   state_type shr;

   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < NB; c++) begin
            shr[r*NB + (c + r) % NB] = st[r*NB + c];
         end
      end
      case (op)
         OP_INV_SHIFT_ROWS: res = shr;
         OP_INV_SUB_BYTES:  res = sub_st;
         OP_INV_MIX_COLS:   res = mix_st;
         default:           res = st;
      endcase
   end
endmodule
